// ===== design/eig_pkg.sv =====
`timescale 1ns / 1ps

package eig_pkg;

   // result field width, signed Q32.16
   localparam int OUT_WIDTH = 48;

   // opcode codes
   localparam logic OP_EIGEN = 1'b0;
   localparam logic OP_ROOT  = 1'b1;

endpackage

// ===== design/eig_sqrt_cell.sv =====
`timescale 1ns / 1ps

module eig_sqrt_cell #(
   parameter int RAD_W  = 66,
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 35
) (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad_i,
   input  logic [ROOT_W+1:0] rem_i,
   input  logic [ROOT_W-1:0] root_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic [RAD_W-1:0]  rad_o,
   output logic [ROOT_W+1:0] rem_o,
   output logic [ROOT_W-1:0] root_o,
   output logic [SIDE_W-1:0] side_o
);

   logic [ROOT_W+3:0] cur;
   logic [ROOT_W+4:0] trial;
   logic              fits;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial = {1'b0, cur} - {3'b000, root_i, 2'b01};
      fits  = ~trial[ROOT_W+4];
   end

   // one root bit per cell, handed on to the neighbor
   always_ff @(posedge clock) begin
      if (en) begin
         rad_o  <= {rad_i[RAD_W-3:0], 2'b00};
         rem_o  <= fits ? trial[ROOT_W+1:0] : cur[ROOT_W+1:0];
         root_o <= {root_i[ROOT_W-2:0], fits};
         side_o <= side_i;
      end
   end

endmodule

// ===== design/eigenvalues_2x2_unit.sv =====
`timescale 1ns / 1ps

// Eigenvalues of a signed fixed-point 2x2 matrix, one matrix per beat. The
// datapath is a full pipeline: three front stages form trace and the exact
// discriminant, a row of IN_WIDTH+1 square-root cells (one root bit each)
// takes sqrt of the discriminant, one stage halves the two roots, a second
// row of (IN_WIDTH+2+FRAC_BITS)/2 cells in two lanes takes the root-mode
// square roots, and an output register saturates to 48 bits. A new matrix
// is taken every cycle in which the pipeline advances. The whole pipeline
// advances when the output register is empty or its beat is taken, so
// req_ready follows rsp_ready.
module eigenvalues_2x2_unit #(
   parameter int FRAC_BITS = 16,
   parameter int IN_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [IN_WIDTH-1:0]          req_elem_00,
   input  logic signed [IN_WIDTH-1:0]          req_elem_01,
   input  logic signed [IN_WIDTH-1:0]          req_elem_10,
   input  logic signed [IN_WIDTH-1:0]          req_elem_11,
   input  logic                                req_opcode,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [eig_pkg::OUT_WIDTH-1:0] rsp_value_first,
   output logic signed [eig_pkg::OUT_WIDTH-1:0] rsp_value_second,
   output logic                                rsp_repeated_or_complex,
   output logic                                rsp_negative_root_flag
);

   import eig_pkg::*;

   localparam int TW  = IN_WIDTH + 1;              // trace, difference
   localparam int PW  = 2 * IN_WIDTH + 2;          // products
   localparam int DW  = 2 * IN_WIDTH + 2;          // discriminant
   localparam int NC1 = IN_WIDTH + 1;              // root bits of sqrt(disc)
   localparam int VW  = IN_WIDTH + 2;              // halved eigenvalue
   localparam int NC2 = (IN_WIDTH + 2 + FRAC_BITS) / 2;
   localparam int R2W = 2 * NC2;
   localparam int SW1 = TW + 2;
   localparam int SWA = VW + 2;
   localparam int SX  = VW + OUT_WIDTH;
   localparam int NV  = NC1 + NC2 + 5;

   localparam logic signed [SX-1:0] SAT_HI = (SX'(1) <<< (OUT_WIDTH - 1)) - SX'(1);
   localparam logic signed [SX-1:0] SAT_LO = -(SX'(1) <<< (OUT_WIDTH - 1));

   logic en;
   logic [NV-1:0] vld_ff;
   logic [NV-1:0] vld_in;

   // pipeline advances when the output register can move
   assign en        = ~vld_ff[NV-1] | rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NV-1];

   // valid bits, one per stage
   always_comb begin
      vld_in = {vld_ff[NV-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: trace and difference of the diagonal
   logic signed [TW-1:0]       diff_ff, tr1_ff;
   logic signed [IN_WIDTH-1:0] b1_ff, c1_ff;
   logic                       op1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= TW'(req_elem_00) - TW'(req_elem_11);
         tr1_ff  <= TW'(req_elem_00) + TW'(req_elem_11);
         b1_ff   <= req_elem_01;
         c1_ff   <= req_elem_10;
         op1_ff  <= req_opcode;
      end
   end

   // stage 2: squared difference and off-diagonal product
   logic signed [PW-1:0] sq_ff, bc_ff;
   logic signed [TW-1:0] tr2_ff;
   logic                 op2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= PW'(diff_ff) * PW'(diff_ff);
         bc_ff  <= PW'(b1_ff) * PW'(c1_ff);
         tr2_ff <= tr1_ff;
         op2_ff <= op1_ff;
      end
   end

   // stage 3: discriminant, zero when not positive
   logic signed [DW:0]   disc_full;
   logic                 pos_w;
   logic [DW-1:0]        disc_ff;
   logic                 pos_ff;
   logic signed [TW-1:0] tr3_ff;
   logic                 op3_ff;

   always_comb begin
      disc_full = (DW+1)'(sq_ff) + ((DW+1)'(bc_ff) <<< 2);
      pos_w     = (disc_full > 0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         disc_ff <= pos_w ? disc_full[DW-1:0] : '0;
         pos_ff  <= pos_w;
         tr3_ff  <= tr2_ff;
         op3_ff  <= op2_ff;
      end
   end

   // row of cells: floor sqrt of the discriminant
   logic [DW-1:0]  rad1_w  [0:NC1];
   logic [NC1+1:0] rem1_w  [0:NC1];
   logic [NC1-1:0] root1_w [0:NC1];
   logic [SW1-1:0] side1_w [0:NC1];

   assign rad1_w[0]  = disc_ff;
   assign rem1_w[0]  = '0;
   assign root1_w[0] = '0;
   assign side1_w[0] = {tr3_ff, op3_ff, pos_ff};

   for (genvar k = 0; k < NC1; k++) begin : g_disc_root
      eig_sqrt_cell #(.RAD_W(DW), .ROOT_W(NC1), .SIDE_W(SW1)) u_cell (
         .clock  (clock),
         .en     (en),
         .rad_i  (rad1_w[k]),
         .rem_i  (rem1_w[k]),
         .root_i (root1_w[k]),
         .side_i (side1_w[k]),
         .rad_o  (rad1_w[k+1]),
         .rem_o  (rem1_w[k+1]),
         .root_o (root1_w[k+1]),
         .side_o (side1_w[k+1])
      );
   end

   // stage 4: halve trace plus and minus the root, flooring
   logic signed [TW-1:0] tr4;
   logic                 op4, pos4;
   logic signed [VW:0]   sum_hi, sum_lo;
   logic signed [VW-1:0] v1_ff, v2_ff;
   logic                 op5_ff, rep5_ff;

   always_comb begin
      {tr4, op4, pos4} = side1_w[NC1];
      sum_hi = (VW+1)'(tr4) + (VW+1)'({1'b0, root1_w[NC1]});
      sum_lo = (VW+1)'(tr4) - (VW+1)'({1'b0, root1_w[NC1]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff   <= sum_hi[VW:1];
         v2_ff   <= sum_lo[VW:1];
         op5_ff  <= op4;
         rep5_ff <= ~pos4;
      end
   end

   // two lanes of cells: root-mode square roots
   logic [R2W-1:0]  rada_w  [0:NC2];
   logic [NC2+1:0]  rema_w  [0:NC2];
   logic [NC2-1:0]  roota_w [0:NC2];
   logic [SWA-1:0]  sidea_w [0:NC2];
   logic [R2W-1:0]  radb_w  [0:NC2];
   logic [NC2+1:0]  remb_w  [0:NC2];
   logic [NC2-1:0]  rootb_w [0:NC2];
   logic [VW-1:0]   sideb_w [0:NC2];

   assign rada_w[0]  = v1_ff[VW-1] ? '0 : R2W'({v1_ff[VW-2:0], {FRAC_BITS{1'b0}}});
   assign radb_w[0]  = v2_ff[VW-1] ? '0 : R2W'({v2_ff[VW-2:0], {FRAC_BITS{1'b0}}});
   assign rema_w[0]  = '0;
   assign remb_w[0]  = '0;
   assign roota_w[0] = '0;
   assign rootb_w[0] = '0;
   assign sidea_w[0] = {v1_ff, op5_ff, rep5_ff};
   assign sideb_w[0] = v2_ff;

   for (genvar k = 0; k < NC2; k++) begin : g_val_root
      eig_sqrt_cell #(.RAD_W(R2W), .ROOT_W(NC2), .SIDE_W(SWA)) u_lane_a (
         .clock  (clock),
         .en     (en),
         .rad_i  (rada_w[k]),
         .rem_i  (rema_w[k]),
         .root_i (roota_w[k]),
         .side_i (sidea_w[k]),
         .rad_o  (rada_w[k+1]),
         .rem_o  (rema_w[k+1]),
         .root_o (roota_w[k+1]),
         .side_o (sidea_w[k+1])
      );
      eig_sqrt_cell #(.RAD_W(R2W), .ROOT_W(NC2), .SIDE_W(VW)) u_lane_b (
         .clock  (clock),
         .en     (en),
         .rad_i  (radb_w[k]),
         .rem_i  (remb_w[k]),
         .root_i (rootb_w[k]),
         .side_i (sideb_w[k]),
         .rad_o  (radb_w[k+1]),
         .rem_o  (remb_w[k+1]),
         .root_o (rootb_w[k+1]),
         .side_o (sideb_w[k+1])
      );
   end

   // output register: select mode, clamp negatives, saturate
   logic signed [VW-1:0]        v1e, v2e;
   logic                        ope, repe;
   logic signed [SX-1:0]        x1, x2;
   logic signed [OUT_WIDTH-1:0] sat1, sat2, first_in, second_in;
   logic                        neg_in;

   always_comb begin
      {v1e, ope, repe} = sidea_w[NC2];
      v2e = sideb_w[NC2];
      x1  = SX'(v1e);
      x2  = SX'(v2e);
      if (x1 > SAT_HI) sat1 = SAT_HI[OUT_WIDTH-1:0];
      else if (x1 < SAT_LO) sat1 = SAT_LO[OUT_WIDTH-1:0];
      else sat1 = x1[OUT_WIDTH-1:0];
      if (x2 > SAT_HI) sat2 = SAT_HI[OUT_WIDTH-1:0];
      else if (x2 < SAT_LO) sat2 = SAT_LO[OUT_WIDTH-1:0];
      else sat2 = x2[OUT_WIDTH-1:0];
      if (ope == OP_ROOT) begin
         first_in  = v1e[VW-1] ? '0 : OUT_WIDTH'(roota_w[NC2]);
         second_in = v2e[VW-1] ? '0 : OUT_WIDTH'(rootb_w[NC2]);
         neg_in    = v1e[VW-1] | v2e[VW-1];
      end else begin
         first_in  = sat1;
         second_in = sat2;
         neg_in    = 1'b0;
      end
   end

   logic signed [OUT_WIDTH-1:0] first_ff, second_ff;
   logic                        rep_ff, neg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         rep_ff    <= repe;
         neg_ff    <= neg_in;
      end
   end

   assign rsp_value_first         = first_ff;
   assign rsp_value_second        = second_ff;
   assign rsp_repeated_or_complex = rep_ff;
   assign rsp_negative_root_flag  = neg_ff;

   // repeated or complex roots give two equal values
   a_rep_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeated_or_complex && !rsp_negative_root_flag
      |-> rsp_value_first == rsp_value_second)
      else $error("repeated roots differ");

   // the plus root never falls below the minus root
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_negative_root_flag |-> rsp_value_first >= rsp_value_second)
      else $error("root order broken");

   // a negative eigenvalue always includes the smaller one, so the second value is zero
   a_neg_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_negative_root_flag |-> rsp_value_second == '0)
      else $error("negative root not clamped");

   // an accepted beat enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat lost");

endmodule
